// ===== rtl/core/bst_pkg.sv =====
package bst_pkg;

    localparam int unsigned DEF_MAX_DEPTH = 64;

    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_INT_FIRST  = 3'd1,
        MODE_INT_DIGITS = 3'd2,
        MODE_LEN_DIGITS = 3'd3,
        MODE_STRING     = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        TK_NULL   = 4'd0,
        TK_TRUE   = 4'd1,
        TK_FALSE  = 4'd2,
        TK_INT    = 4'd3,
        TK_HEADER = 4'd4,
        TK_SBYTE  = 4'd5,
        TK_LIST   = 4'd6,
        TK_DICT   = 4'd7,
        TK_END    = 4'd8,
        TK_ERROR  = 4'd9
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [63:0] int_value;
        logic [30:0] string_length;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [6:0]  depth;
        logic        overflow;
    } t_token;

endpackage

// ===== rtl/core/bst_parser.sv =====
module bst_parser #(
    parameter int unsigned MAX_DEPTH = bst_pkg::DEF_MAX_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    output bst_pkg::t_token o_token
);
    import bst_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

    t_mode         r_mode, n_mode;
    logic [63:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic [30:0]   r_left, n_left;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_ovf, n_ovf;

    logic          is_dig;
    logic [3:0]    dval;
    logic [67:0]   int_sum;
    logic          int_step_ovf;
    logic [30:0]   acc_len;
    logic [34:0]   len_sum;
    logic          len_sat;
    logic [30:0]   left_dec;
    logic [63:0]   fin_value;
    logic          fin_ovf;
    logic [DW+6:0] depth_wide;

    assign is_dig = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign dval   = 4'(i_byte - CH_0);

    // Times ten as two shifts and an add; the top four bits catch a wrap past 64 bits.
    assign int_sum      = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + 68'(dval);
    assign int_step_ovf = |int_sum[67:64];

    assign acc_len = r_acc[30:0];
    assign len_sum = {1'b0, acc_len, 3'b000} + {3'b000, acc_len, 1'b0} + 35'(dval);
    assign len_sat = len_sum > {4'b0000, LEN_MAX};

    assign left_dec = (r_left == 31'd0) ? 31'd0 : r_left - 31'd1;

    assign fin_value = r_neg ? (64'd0 - r_acc) : r_acc;
    assign fin_ovf   = r_ovf | (r_neg ? (r_acc[63] & (|r_acc[62:0])) : r_acc[63]);

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_left  = r_left;
        n_depth = r_depth;
        n_ovf   = r_ovf;
        if (i_fire) begin
            case (r_mode)
                MODE_INT_FIRST: begin
                    if (i_byte == CH_MINUS) begin
                        n_neg  = 1'b1;
                        n_mode = MODE_INT_DIGITS;
                    end else if (is_dig) begin
                        n_acc  = 64'(dval);
                        n_mode = MODE_INT_DIGITS;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_INT_DIGITS: begin
                    if (is_dig) begin
                        n_acc = int_sum[63:0];
                        n_ovf = r_ovf | int_step_ovf;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_LEN_DIGITS: begin
                    if (is_dig) begin
                        n_acc = len_sat ? 64'(LEN_MAX) : 64'(len_sum);
                        n_ovf = r_ovf | len_sat;
                    end else begin
                        n_left = acc_len;
                        n_mode = (acc_len == 31'd0) ? MODE_IDLE : MODE_STRING;
                    end
                end
                MODE_STRING: begin
                    n_left = left_dec;
                    if (left_dec == 31'd0) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (i_byte == CH_I) begin
                        n_mode = MODE_INT_FIRST;
                        n_acc  = 64'd0;
                        n_neg  = 1'b0;
                        n_ovf  = 1'b0;
                    end else if (is_dig) begin
                        n_mode = MODE_LEN_DIGITS;
                        n_acc  = 64'(dval);
                        n_ovf  = 1'b0;
                    end else if (i_byte == CH_E) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - DEPTH_ONE;
                        end
                    end else if (i_byte == CH_L || i_byte == CH_D) begin
                        if (r_depth != DEPTH_LIMIT) begin
                            n_depth = r_depth + DEPTH_ONE;
                        end
                    end
                end
            endcase
        end
    end

    assign depth_wide = {7'd0, n_depth};

    always_comb begin
        o_token               = '0;
        o_token.kind          = TK_ERROR;
        o_token.depth         = depth_wide[6:0];
        case (r_mode)
            MODE_INT_FIRST, MODE_INT_DIGITS: begin
                if (!is_dig && !(r_mode == MODE_INT_FIRST && i_byte == CH_MINUS)) begin
                    o_token.valid     = i_fire;
                    o_token.kind      = TK_INT;
                    o_token.int_value = fin_value;
                    o_token.overflow  = fin_ovf;
                end
            end
            MODE_LEN_DIGITS: begin
                if (!is_dig) begin
                    o_token.valid         = i_fire;
                    o_token.kind          = TK_HEADER;
                    o_token.string_length = acc_len;
                    o_token.overflow      = r_ovf;
                end
            end
            MODE_STRING: begin
                o_token.valid     = i_fire;
                o_token.kind      = TK_SBYTE;
                o_token.data_byte = i_byte;
                o_token.last_byte = (left_dec == 31'd0);
            end
            default: begin
                o_token.valid = i_fire && !(i_byte == CH_I) && !is_dig;
                if (i_byte == CH_N) begin
                    o_token.kind = TK_NULL;
                end else if (i_byte == CH_T) begin
                    o_token.kind = TK_TRUE;
                end else if (i_byte == CH_F) begin
                    o_token.kind = TK_FALSE;
                end else if (i_byte == CH_E) begin
                    o_token.kind = (r_depth != '0) ? TK_END : TK_ERROR;
                end else if (i_byte == CH_L) begin
                    o_token.kind = (r_depth != DEPTH_LIMIT) ? TK_LIST : TK_ERROR;
                end else if (i_byte == CH_D) begin
                    o_token.kind = (r_depth != DEPTH_LIMIT) ? TK_DICT : TK_ERROR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= 64'd0;
            r_neg   <= 1'b0;
            r_left  <= 31'd0;
            r_depth <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_left  <= n_left;
            r_depth <= n_depth;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== rtl/core/bst_out_reg.sv =====
module bst_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  bst_pkg::t_token i_token,
    output logic            o_valid,
    output bst_pkg::t_token o_token
);
    import bst_pkg::*;

    logic   r_valid;
    t_token r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_token.valid;
        end
    end

    // The payload only moves for a valid token, and only when the register is empty or its word has been taken.
    always_ff @(posedge i_clk) begin
        if (i_advance && i_token.valid) begin
            r_token <= i_token;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

// ===== rtl/core/bencode_stream_tokenizer_top.sv =====
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_in_byte
// output    o_out_valid / i_out_ready  o_token_kind, o_int_value, o_string_length,
//                                      o_data_byte, o_last_byte, o_depth, o_overflow
//
// One byte per cycle is sustained while the output does not stall: a byte waits in
// the input register, the parser updates its state and forms the token as the byte
// fires, and the token lands in the output register, whose valid flags it for output.
// Bytes that open a number or continue one produce no token.
// Reset (synchronous, active low) returns the parser to awaiting a lead byte at depth 0.
// A stalled output holds its word and backs up into the input register only then.
module bencode_stream_tokenizer_top #(
    parameter int unsigned MAX_DEPTH = bst_pkg::DEF_MAX_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_token_kind,
    output logic signed [63:0] o_int_value,
    output logic [30:0]        o_string_length,
    output logic [7:0]         o_data_byte,
    output logic               o_last_byte,
    output logic [6:0]         o_depth,
    output logic               o_overflow
);
    import bst_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       fire;
    t_token     step_token;
    t_token     out_token;

    assign advance    = !o_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    bst_parser #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_byte (r_in_byte),
        .o_token(step_token)
    );

    bst_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_token  (step_token),
        .o_valid  (o_out_valid),
        .o_token  (out_token)
    );

    assign o_token_kind    = out_token.kind;
    assign o_int_value     = out_token.int_value;
    assign o_string_length = out_token.string_length;
    assign o_data_byte     = out_token.data_byte;
    assign o_last_byte     = out_token.last_byte;
    assign o_depth         = out_token.depth;
    assign o_overflow      = out_token.overflow;

endmodule

// ===== rtl/core/bst_checker.sv =====
module bst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [3:0]         o_token_kind,
    input logic signed [63:0] o_int_value,
    input logic [30:0]        o_string_length,
    input logic [7:0]         o_data_byte,
    input logic               o_last_byte,
    input logic [6:0]         o_depth,
    input logic               o_overflow
);
    import bst_pkg::*;

    // A stalled word keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_int_value) && $stable(o_string_length) && $stable(o_data_byte)
            && $stable(o_last_byte) && $stable(o_depth) && $stable(o_overflow))
        else $error("output word changed while stalled");

    a_ovf_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_token_kind == TK_INT || o_token_kind == TK_HEADER)
        else $error("overflow flag on a token that carries no number");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != TK_INT |-> o_int_value == 64'sd0)
        else $error("integer value set on a non-integer token");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind bencode_stream_tokenizer_top bst_checker u_bst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_token_kind   (o_token_kind),
    .o_int_value    (o_int_value),
    .o_string_length(o_string_length),
    .o_data_byte    (o_data_byte),
    .o_last_byte    (o_last_byte),
    .o_depth        (o_depth),
    .o_overflow     (o_overflow)
);
